[hdl/t2r_pkg.sv]
// shared types, constants and pixel packing function for the tile to raster converter
`timescale 1ns / 1ps
`default_nettype none

package t2r_pkg;

  localparam int unsigned ROWS_PER_TILE = 8;
  localparam int unsigned PLANES        = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
  } t2r_beat_t;

  function automatic logic [7:0] interleave(input logic [3:0] lo, input logic [3:0] hi);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[2*k+1] = hi[k];
      r[2*k]   = lo[k];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/tile_to_raster_2bpp_converter.sv]
// top level of the 2bpp planar tile to row-major packed pixel converter
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   input   | in        | in_valid / in_stall  | operation, tile_byte
//   output  | out       | out_valid / out_stall| first_pixels, second_pixels, last_of_frame
//
// one beat accepted per cycle while in_stall is low, loads and reads alike; a read beat
// yields its result through the plane memory read register, then the result register
// rst clears the load and read counters and the pipeline; frame store contents stay
// undefined until loaded, no clearing pass
// in_stall rises only while a result is held in the output register and a read is
// waiting behind it
`timescale 1ns / 1ps
`default_nettype none

module tile_to_raster_2bpp_converter
  import t2r_pkg::*;
#(
  parameter int unsigned TILES_ACROSS = 16,
  parameter int unsigned TILE_ROWS    = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       operation,
  input  wire logic [7:0] tile_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      first_pixels,
  output logic [7:0]      second_pixels,
  output logic            last_of_frame
);

  localparam int unsigned FRAME_PAIRS = TILES_ACROSS * TILE_ROWS * ROWS_PER_TILE;
  localparam int unsigned PAIR_W      = $clog2(FRAME_PAIRS);

  logic              accept;
  logic              load_en;
  logic              read_en;
  logic              advance;
  logic [PAIR_W-1:0] load_addr;
  logic              load_plane;
  logic [PAIR_W-1:0] read_pos;
  logic              read_last;
  logic [7:0]        rd_lo;
  logic [7:0]        rd_hi;
  t2r_beat_t         beat;

  assign in_stall  = beat.valid && !advance;
  assign accept    = in_valid && !in_stall;
  assign load_en   = accept && (operation == OP_LOAD);
  assign read_en   = accept && (operation == OP_READ);
  assign read_last = (read_pos == PAIR_W'(FRAME_PAIRS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos <= '0;
    end else if (read_en) begin
      read_pos <= read_last ? '0 : read_pos + PAIR_W'(1);
    end
  end

  // memory read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
      beat.last  <= 1'b0;
    end else if (!in_stall) begin
      beat.valid <= read_en;
      beat.last  <= read_last;
    end
  end

  t2r_load_ctrl #(
    .TILES_ACROSS (TILES_ACROSS),
    .TILE_ROWS    (TILE_ROWS),
    .PAIR_W       (PAIR_W)
  ) u_load_ctrl (
    .clk   (clk),
    .rst   (rst),
    .step  (load_en),
    .addr  (load_addr),
    .plane (load_plane)
  );

  t2r_frame_store #(
    .DEPTH  (FRAME_PAIRS),
    .PAIR_W (PAIR_W)
  ) u_frame_store (
    .clk      (clk),
    .wr_en    (load_en),
    .wr_addr  (load_addr),
    .wr_plane (load_plane),
    .wr_data  (tile_byte),
    .rd_en    (read_en),
    .rd_addr  (read_pos),
    .rd_lo    (rd_lo),
    .rd_hi    (rd_hi)
  );

  t2r_out_stage u_out_stage (
    .clk           (clk),
    .rst           (rst),
    .beat          (beat),
    .lo            (rd_lo),
    .hi            (rd_hi),
    .out_stall     (out_stall),
    .advance       (advance),
    .out_valid     (out_valid),
    .first_pixels  (first_pixels),
    .second_pixels (second_pixels),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire

[hdl/t2r_load_ctrl.sv]
// load address generator: walks tile order and yields the row-major pair address and plane
`timescale 1ns / 1ps
`default_nettype none

module t2r_load_ctrl
  import t2r_pkg::*;
#(
  parameter int unsigned TILES_ACROSS = 16,
  parameter int unsigned TILE_ROWS    = 16,
  parameter int unsigned PAIR_W       = 11
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  output logic [PAIR_W-1:0]      addr,
  output logic                   plane
);

  localparam int unsigned TX_W  = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
  localparam int unsigned TY_W  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int unsigned RIT_W = $clog2(ROWS_PER_TILE);

  logic [RIT_W-1:0] row_in_tile;
  logic [TX_W-1:0]  tile_x;
  logic [TY_W-1:0]  tile_y;

  logic             plane_next;
  logic [RIT_W-1:0] row_in_tile_next;
  logic [TX_W-1:0]  tile_x_next;
  logic [TY_W-1:0]  tile_y_next;
  logic [PAIR_W-1:0] addr_next;

  always_comb begin
    plane_next       = ~plane;
    row_in_tile_next = row_in_tile;
    tile_x_next      = tile_x;
    tile_y_next      = tile_y;
    addr_next        = addr;
    if (plane) begin
      if (row_in_tile != RIT_W'(ROWS_PER_TILE - 1)) begin
        row_in_tile_next = row_in_tile + RIT_W'(1);
        addr_next        = addr + PAIR_W'(TILES_ACROSS);
      end else begin
        row_in_tile_next = '0;
        if (tile_x != TX_W'(TILES_ACROSS - 1)) begin
          // back to the top row of the next tile across
          tile_x_next = tile_x + TX_W'(1);
          addr_next   = addr - PAIR_W'((ROWS_PER_TILE - 1) * TILES_ACROSS - 1);
        end else begin
          tile_x_next = '0;
          if (tile_y != TY_W'(TILE_ROWS - 1)) begin
            tile_y_next = tile_y + TY_W'(1);
            addr_next   = addr + PAIR_W'(1);
          end else begin
            tile_y_next = '0;
            addr_next   = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane       <= 1'b0;
      row_in_tile <= '0;
      tile_x      <= '0;
      tile_y      <= '0;
      addr        <= '0;
    end else if (step) begin
      plane       <= plane_next;
      row_in_tile <= row_in_tile_next;
      tile_x      <= tile_x_next;
      tile_y      <= tile_y_next;
      addr        <= addr_next;
    end
  end

endmodule

`default_nettype wire

[hdl/t2r_frame_store.sv]
// frame store: one memory per plane, indexed by row-major pair, registered read
`timescale 1ns / 1ps
`default_nettype none

module t2r_frame_store #(
  parameter int unsigned DEPTH  = 2048,
  parameter int unsigned PAIR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [PAIR_W-1:0] wr_addr,
  input  wire logic              wr_plane,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [PAIR_W-1:0] rd_addr,
  output logic [7:0]             rd_lo,
  output logic [7:0]             rd_hi
);

  logic [7:0] mem_lo [DEPTH];
  logic [7:0] mem_hi [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en && !wr_plane) begin
      mem_lo[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_lo <= mem_lo[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_plane) begin
      mem_hi[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_hi <= mem_hi[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/t2r_out_stage.sv]
// result register: packs plane bytes into pixel bytes and holds them for the output beat
`timescale 1ns / 1ps
`default_nettype none

module t2r_out_stage
  import t2r_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire t2r_beat_t  beat,
  input  wire logic [7:0] lo,
  input  wire logic [7:0] hi,
  input  wire logic       out_stall,
  output logic            advance,
  output logic            out_valid,
  output logic [7:0]      first_pixels,
  output logic [7:0]      second_pixels,
  output logic            last_of_frame
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && beat.valid) begin
      first_pixels  <= interleave(lo[7:4], hi[7:4]);
      second_pixels <= interleave(lo[3:0], hi[3:0]);
      last_of_frame <= beat.last;
    end
  end

endmodule

`default_nettype wire

[hdl/t2r_checker.sv]
// port-level checker for the tile to raster converter and its bind
`timescale 1ns / 1ps
`default_nettype none

module t2r_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] first_pixels,
  input wire logic [7:0] second_pixels,
  input wire logic       last_of_frame
);

  // an offered input beat stays up until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input beat withdrawn while stalled");

  // a held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(first_pixels) && $stable(second_pixels)
      && $stable(last_of_frame))
    else $error("output payload changed while stalled");

  // input backpressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind tile_to_raster_2bpp_converter t2r_checker u_t2r_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .first_pixels  (first_pixels),
  .second_pixels (second_pixels),
  .last_of_frame (last_of_frame)
);

`default_nettype wire
